>>> sv/gpf_pkg.sv
// shared types and constants of the grid peak finder
package gpf_pkg;

	// field widths
	localparam int SizeW   = 11;
	localparam int HeightW = 31;
	// internal coordinates carry headroom for window bounds one past the grid
	localparam int CoordW  = 12;
	// largest side that the 11-bit size register can express
	localparam int SizeMax = 2047;

	// internal phase steps allowed per response before a forced zero answer
	localparam int LoopCap = 8;
	localparam int CntW    = $clog2(LoopCap);

	// stream and register codes
	localparam logic OpStart    = 1'b0;
	localparam logic OpResponse = 1'b1;
	localparam logic KindRequest = 1'b0;
	localparam logic KindAnswer  = 1'b1;
	localparam int   ApbAddrW    = 3;
	localparam logic RegGridSize = 1'b0;

	// stream tdata widths
	localparam int OutDataW = 56;
	localparam int InDataW  = 32;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT_SCAN,
		ST_WAIT_N1,
		ST_WAIT_N2,
		ST_WAIT_LAST,
		ST_BEGIN,
		ST_SCAN,
		ST_AFTER,
		ST_SECOND,
		ST_DECIDE,
		ST_LAST_ANS
	} gpf_state_t;

	// what the output register is loaded with
	typedef enum logic [2:0] {
		EMIT_REQ_SCAN,
		EMIT_REQ_SINGLE,
		EMIT_REQ_N1,
		EMIT_REQ_N2,
		EMIT_ANS_ZERO,
		EMIT_ANS_BEST,
		EMIT_ANS_SECOND
	} emit_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      start;
		logic      take_scan;
		logic      skip_cell;
		logic      begin_phase;
		logic      after_move;
		logic      decide_move;
		logic      load_first;
		logic      load_second;
		logic      use_zero;
		logic      emit;
		emit_sel_t emit_sel;
	} gpf_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic single_cell;
		logic single_in_grid;
		logic scan_done;
		logic scan_in_grid;
		logic moved;
		logic n1_in_grid;
		logic n2_in_grid;
		logic best_is_peak;
		logic out_free;
	} gpf_stat_t;

endpackage

>>> sv/grid_peak_finder.sv
// top level of the grid peak finder: register port, controller and datapath
//
// Searches for a local peak in a square grid of heights held outside the block.
// The slave stream takes items: tuser selects start (0) or height response (1),
// tdata carries the height. The master stream gives one request per step:
// tuser 0 asks for cell (x, y), 1-based; tuser 1 is the answer with the peak
// height. Feed each requested height back on the slave stream.
// The grid side is set over the APB port (register 0, 11 bits); the user must set it
// only while idle, which the block itself does not enforce. It is taken when a start
// arrives; 0 counts as 1, sizes above MAX_GRID are clipped. After a response is
// accepted the controller walks its internal steps (phase begin, neighbour checks,
// decision) and skips out-of-grid cells of a scan one by one, then the result sits
// in the output register; a move toward the previous peak and each skipped cell
// add steps before the result.
// The controller handles one item at a time; s_tready is low while it steps.
// The input is taken while a result still waits in the output register; when
// the receiver stalls with that register full, the next step waits for it.
// Reset empties the output register, returns to idle and sets the size to 1.
module grid_peak_finder
	import gpf_pkg::*;
#(
	parameter int MAX_GRID = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // [30:0] height, [31] zero
	input  logic [0:0]          s_tuser,  // [0] operation
	// master stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // [10:0] cell_x, [21:11] cell_y,
	                                      // [52:22] peak_height, [55:53] zero
	output logic [0:0]          m_tuser,  // [0] is_answer
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [SizeW-1:0]   grid_size_q;
	gpf_cmd_t           cmd;
	gpf_stat_t          stat;
	logic               out_is_answer;
	logic [SizeW-1:0]   out_x, out_y;
	logic [HeightW-1:0] out_height;

	// grid size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SizeW'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == RegGridSize)) begin
			grid_size_q <= pwdata[SizeW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegGridSize) ? 32'(grid_size_q) : '0;

	gpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gpf_dpath #(
		.MAX_GRID (MAX_GRID)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.grid_size     (grid_size_q),
		.in_height     (s_tdata[HeightW-1:0]),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_is_answer (out_is_answer),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_height    (out_height)
	);

	// pack result fields
	assign m_tuser = out_is_answer;
	assign m_tdata = {3'b000, out_height, out_y, out_x};

endmodule

>>> sv/gpf_ctrl.sv
// controller state machine of the grid peak finder
module gpf_ctrl
	import gpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_op,
	output logic      in_ready,
	input  gpf_stat_t stat,
	output gpf_cmd_t  cmd
);

	gpf_state_t      state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            brk;
	logic            last;
	logic            go;

	assign last = (cnt_q == CntW'(LoopCap - 1));
	assign go   = stat.out_free;

	// state and phase step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				cnt_q <= '0;
			end else if (brk) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_WAIT_SCAN, ST_WAIT_N1, ST_WAIT_N2, ST_WAIT_LAST: begin
				if (in_valid) begin
					if (in_op == OpStart) begin
						state_d = ST_BEGIN;
					end else begin
						unique case (state_q)
							ST_WAIT_SCAN: state_d = ST_SCAN;
							ST_WAIT_N1:   state_d = ST_SECOND;
							ST_WAIT_N2:   state_d = ST_DECIDE;
							ST_WAIT_LAST: state_d = ST_LAST_ANS;
							default:      state_d = ST_IDLE;
						endcase
					end
				end
			end
			ST_BEGIN: begin
				if (go) begin
					if (stat.single_cell) begin
						state_d = stat.single_in_grid ? ST_WAIT_LAST : ST_IDLE;
					end else begin
						state_d = last ? ST_IDLE : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (go) begin
					if (stat.scan_done) begin
						state_d = last ? ST_IDLE : ST_AFTER;
					end else if (stat.scan_in_grid) begin
						state_d = ST_WAIT_SCAN;
					end
				end
			end
			ST_AFTER: begin
				if (go) begin
					if (stat.moved) begin
						state_d = last ? ST_IDLE : ST_BEGIN;
					end else if (stat.n1_in_grid) begin
						state_d = ST_WAIT_N1;
					end else begin
						state_d = last ? ST_IDLE : ST_SECOND;
					end
				end
			end
			ST_SECOND: begin
				if (go) begin
					if (stat.n2_in_grid) begin
						state_d = ST_WAIT_N2;
					end else begin
						state_d = last ? ST_IDLE : ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (go) begin
					if (stat.best_is_peak) begin
						state_d = ST_IDLE;
					end else begin
						state_d = last ? ST_IDLE : ST_BEGIN;
					end
				end
			end
			ST_LAST_ANS: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands, ready and phase step marks
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		brk      = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_WAIT_SCAN, ST_WAIT_N1, ST_WAIT_N2, ST_WAIT_LAST: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OpStart) begin
						cmd.start = 1'b1;
					end else begin
						unique case (state_q)
							ST_WAIT_SCAN: cmd.take_scan   = 1'b1;
							ST_WAIT_N1:   cmd.load_first  = 1'b1;
							ST_WAIT_N2:   cmd.load_second = 1'b1;
							ST_WAIT_LAST: cmd.load_second = 1'b1;
							default:      cmd.start       = 1'b0;
						endcase
					end
				end
			end
			ST_BEGIN: begin
				if (go) begin
					if (stat.single_cell) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = stat.single_in_grid ? EMIT_REQ_SINGLE : EMIT_ANS_ZERO;
					end else begin
						cmd.begin_phase = 1'b1;
						brk             = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (go) begin
					if (stat.scan_done) begin
						brk = 1'b1;
					end else if (stat.scan_in_grid) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_REQ_SCAN;
					end else begin
						cmd.skip_cell = 1'b1;
					end
				end
			end
			ST_AFTER: begin
				if (go) begin
					if (stat.moved) begin
						cmd.after_move = 1'b1;
						brk            = 1'b1;
					end else if (stat.n1_in_grid) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_REQ_N1;
					end else begin
						cmd.load_first = 1'b1;
						cmd.use_zero   = 1'b1;
						brk            = 1'b1;
					end
				end
			end
			ST_SECOND: begin
				if (go) begin
					if (stat.n2_in_grid) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_REQ_N2;
					end else begin
						cmd.load_second = 1'b1;
						cmd.use_zero    = 1'b1;
						brk             = 1'b1;
					end
				end
			end
			ST_DECIDE: begin
				if (go) begin
					if (stat.best_is_peak) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_ANS_BEST;
					end else begin
						cmd.decide_move = 1'b1;
						brk             = 1'b1;
					end
				end
			end
			ST_LAST_ANS: begin
				if (go) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_ANS_SECOND;
				end
			end
			default: in_ready = 1'b0;
		endcase
		// step limit reached: give up with a zero answer
		if (brk && last) begin
			cmd.emit     = 1'b1;
			cmd.emit_sel = EMIT_ANS_ZERO;
		end
	end

endmodule

>>> sv/gpf_dpath.sv
// window, scan and best-cell datapath of the grid peak finder
module gpf_dpath
	import gpf_pkg::*;
#(
	parameter int MAX_GRID = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SizeW-1:0]   grid_size,
	input  logic [HeightW-1:0] in_height,
	input  gpf_cmd_t           cmd,
	output gpf_stat_t          stat,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               out_is_answer,
	output logic [SizeW-1:0]   out_x,
	output logic [SizeW-1:0]   out_y,
	output logic [HeightW-1:0] out_height
);

	localparam int ClipSize = (MAX_GRID > SizeMax) ? SizeMax : MAX_GRID;

	logic [CoordW-1:0]  size_q;
	logic [CoordW-1:0]  x_low_q, x_high_q, y_low_q, y_high_q;
	logic [CoordW-1:0]  prev_x_q, prev_y_q;
	logic [HeightW-1:0] prev_h_q;
	logic               col_q;
	logic [CoordW-1:0]  scan_pos_q;
	logic [HeightW-1:0] best_h_q;
	logic [CoordW-1:0]  best_x_q, best_y_q;
	logic [HeightW-1:0] first_q, second_q;

	logic               out_valid_q, out_is_ans_q;
	logic [SizeW-1:0]   out_x_q, out_y_q;
	logic [HeightW-1:0] out_h_q;

	logic [CoordW-1:0]  clip_size;
	logic [CoordW:0]    x_sum, y_sum;
	logic [CoordW-1:0]  x_mid, y_mid, mid;
	logic [CoordW-1:0]  sx, sy, scan_end, prev_p;
	logic [CoordW-1:0]  n1x, n1y, n2x, n2y;
	logic [HeightW-1:0] take_h, load_h;
	logic               take_wins;

	function automatic logic in_grid(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
			input logic [CoordW-1:0] n);
		in_grid = (x != '0) && (x <= n) && (y != '0) && (y <= n);
	endfunction

	// size latched at start, clipped to 1..MAX_GRID and to SizeMax
	always_comb begin
		if (grid_size == '0) begin
			clip_size = CoordW'(1);
		end else if (32'(grid_size) > ClipSize) begin
			clip_size = CoordW'(ClipSize);
		end else begin
			clip_size = CoordW'(grid_size);
		end
	end

	// middle row and column of the window
	assign x_sum = {1'b0, x_low_q} + {1'b0, x_high_q};
	assign y_sum = {1'b0, y_low_q} + {1'b0, y_high_q};
	assign x_mid = x_sum[CoordW:1];
	assign y_mid = y_sum[CoordW:1];
	assign mid   = col_q ? x_mid : y_mid;

	// scan cell and neighbours of the best cell
	assign sx       = col_q ? x_mid : scan_pos_q;
	assign sy       = col_q ? scan_pos_q : y_mid;
	assign scan_end = col_q ? y_high_q : x_high_q;
	assign prev_p   = col_q ? prev_x_q : prev_y_q;
	assign n1x      = col_q ? best_x_q - 1'b1 : best_x_q;
	assign n1y      = col_q ? best_y_q : best_y_q + 1'b1;
	assign n2x      = col_q ? best_x_q + 1'b1 : best_x_q;
	assign n2y      = col_q ? best_y_q : best_y_q - 1'b1;

	// running maximum, ties to the larger coordinates
	assign take_h    = cmd.skip_cell ? '0 : in_height;
	assign take_wins = (take_h > best_h_q) || ((take_h == best_h_q) &&
		((sx > best_x_q) || ((sx == best_x_q) && (sy > best_y_q))));
	assign load_h    = cmd.use_zero ? '0 : in_height;

	// status to the controller
	always_comb begin
		stat.single_cell    = (x_low_q == x_high_q) && (y_low_q == y_high_q);
		stat.single_in_grid = in_grid(x_low_q, y_high_q, size_q);
		stat.scan_done      = scan_pos_q > scan_end;
		stat.scan_in_grid   = in_grid(sx, sy, size_q);
		stat.moved          = (best_h_q < prev_h_q) && (prev_p != mid);
		stat.n1_in_grid     = in_grid(n1x, n1y, size_q);
		stat.n2_in_grid     = in_grid(n2x, n2y, size_q);
		stat.best_is_peak   = (best_h_q > first_q) && (best_h_q > second_q);
		stat.out_free       = !out_valid_q || out_ready;
	end

	// search state
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			size_q   <= clip_size;
			x_low_q  <= CoordW'(1);
			x_high_q <= clip_size;
			y_low_q  <= CoordW'(1);
			y_high_q <= clip_size;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
			col_q    <= 1'b0;
		end
		if (cmd.take_scan || cmd.skip_cell) begin
			if (take_wins) begin
				best_h_q <= take_h;
				best_x_q <= sx;
				best_y_q <= sy;
			end
			scan_pos_q <= scan_pos_q + 1'b1;
		end
		if (cmd.begin_phase) begin
			best_h_q   <= '0;
			best_x_q   <= '0;
			best_y_q   <= '0;
			scan_pos_q <= col_q ? y_low_q : x_low_q;
		end
		if (cmd.load_first) begin
			first_q <= load_h;
		end
		if (cmd.load_second) begin
			second_q <= load_h;
		end
		// previous peak is higher and lies off the middle line: move toward it
		if (cmd.after_move) begin
			if (prev_p > mid) begin
				if (col_q) x_low_q <= mid + 1'b1;
				else y_low_q <= mid;
			end else begin
				if (col_q) x_high_q <= mid;
				else y_high_q <= mid + 1'b1;
			end
			col_q <= !col_q;
		end
		// not a peak: move toward the higher neighbour
		if (cmd.decide_move) begin
			if (col_q) begin
				if (first_q > second_q) x_high_q <= best_x_q;
				else x_low_q <= best_x_q + 1'b1;
			end else begin
				if (first_q > second_q) y_low_q <= mid;
				else y_high_q <= mid + 1'b1;
			end
			prev_x_q <= best_x_q;
			prev_y_q <= best_y_q;
			prev_h_q <= best_h_q;
			col_q    <= !col_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.emit_sel)
				EMIT_REQ_SCAN: begin
					out_is_ans_q <= KindRequest;
					out_x_q      <= sx[SizeW-1:0];
					out_y_q      <= sy[SizeW-1:0];
					out_h_q      <= '0;
				end
				EMIT_REQ_SINGLE: begin
					out_is_ans_q <= KindRequest;
					out_x_q      <= x_low_q[SizeW-1:0];
					out_y_q      <= y_high_q[SizeW-1:0];
					out_h_q      <= '0;
				end
				EMIT_REQ_N1: begin
					out_is_ans_q <= KindRequest;
					out_x_q      <= n1x[SizeW-1:0];
					out_y_q      <= n1y[SizeW-1:0];
					out_h_q      <= '0;
				end
				EMIT_REQ_N2: begin
					out_is_ans_q <= KindRequest;
					out_x_q      <= n2x[SizeW-1:0];
					out_y_q      <= n2y[SizeW-1:0];
					out_h_q      <= '0;
				end
				EMIT_ANS_BEST: begin
					out_is_ans_q <= KindAnswer;
					out_x_q      <= '0;
					out_y_q      <= '0;
					out_h_q      <= best_h_q;
				end
				EMIT_ANS_SECOND: begin
					out_is_ans_q <= KindAnswer;
					out_x_q      <= '0;
					out_y_q      <= '0;
					out_h_q      <= second_q;
				end
				default: begin
					out_is_ans_q <= KindAnswer;
					out_x_q      <= '0;
					out_y_q      <= '0;
					out_h_q      <= '0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_is_answer = out_is_ans_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign out_height    = out_h_q;

endmodule

>>> sv/gpf_checker.sv
// port-level checks of the grid peak finder and their bind
module gpf_checker
	import gpf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic [0:0]          m_tuser,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [ApbAddrW-1:0] paddr,
	input logic [31:0]         pwdata,
	input logic [31:0]         prdata
);

	// an answer carries no cell
	ap_answer_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[21:0] == '0)
		else $error("answer with nonzero cell");

	// a request names a cell with nonzero coordinates and no height
	ap_request_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tdata[10:0] != '0 && m_tdata[21:11] != '0 && m_tdata[52:22] == '0)
		else $error("malformed cell request");

	// stalled result holds
	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

	// size register reads back what was written
	ap_size_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == '0 |=>
			paddr != '0 || prdata[10:0] == $past(pwdata[10:0]))
		else $error("grid size readback mismatch");

endmodule

bind grid_peak_finder gpf_checker u_gpf_checker (.*);
